// ===== rtl/hrnd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrnd_pkg
// Shared types and constants of the RPU NAL deframer.
// ----------------------------------------------------------------------------
package hrnd_pkg;

  localparam int unsigned MAX_RESULTS     = 4;
  localparam int unsigned IDX_W           = $clog2(MAX_RESULTS);
  localparam int unsigned CNT_W           = $clog2(MAX_RESULTS + 1);
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] ESCAPE_BYTE   = 8'h03;
  localparam logic [7:0] START_BYTE    = 8'h01;
  localparam logic [7:0] ZERO_BYTE     = 8'h00;
  localparam logic [7:0] NAL_TYPE_MASK = 8'h3f;
  localparam logic [5:0] NAL_TYPE_RPU  = 6'd62;

  localparam logic [2:0] LEN_BYTES_RESET = 3'd4;
  localparam logic [2:0] LEN_BYTES_MIN   = 3'd1;
  localparam logic [2:0] LEN_BYTES_MAX   = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } pkt_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_truncated;
  } nal_item_t;

  typedef struct packed {
    nal_item_t [MAX_RESULTS-1:0] res;
    logic [CNT_W-1:0]            count;
  } bundle_t;

endpackage : hrnd_pkg
`default_nettype wire

// ===== rtl/hrnd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrnd_front
// Framing detection, NAL splitting and unescaping; emits at most one result
// bundle per step.
// ----------------------------------------------------------------------------
module hrnd_front
  import hrnd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       pkt_valid,
  output logic            pkt_ready,
  input  wire pkt_item_t  pkt_item,
  input  wire logic       cfg_wr_en,
  input  wire logic [2:0] cfg_wr_data,
  input  wire logic       q_full,
  output logic            q_push,
  output bundle_t         q_data
);

  localparam logic [1:0] FM_UNDECIDED = 2'd0;
  localparam logic [1:0] FM_SEARCH    = 2'd1;
  localparam logic [1:0] FM_UNIT      = 2'd2;
  localparam logic [1:0] FM_LENGTH    = 2'd3;

  typedef struct packed {
    logic [1:0] hdr_seen;
    logic       selected;
    logic [1:0] zero_run;
    logic [7:0] held;
    logic       held_valid;
  } unit_t;

  typedef struct packed {
    logic [1:0]  fm;
    logic [7:0]  la0;
    logic [7:0]  la1;
    logic [1:0]  lc;
    logic [31:0] lr;
    logic [2:0]  psn;
    logic        stopped;
    unit_t       unit;
  } fs_t;

  typedef struct packed {
    fs_t     s;
    bundle_t o;
  } ctx_t;

  localparam unit_t UNIT_CLEAR = '0;
  localparam fs_t   FS_RESET   = '0;

  function automatic ctx_t f_emit(ctx_t c, logic [7:0] b, logic last, logic trunc);
    nal_item_t it;
    it.out_byte      = b;
    it.out_last      = last;
    it.out_truncated = trunc;
    if (c.o.count < CNT_W'(MAX_RESULTS)) begin
      c.o.res[c.o.count[IDX_W-1:0]] = it;
      c.o.count = c.o.count + 1'b1;
    end
    return c;
  endfunction

  function automatic ctx_t f_feed(ctx_t c, logic [7:0] b);
    if (c.s.unit.hdr_seen < 2'd2) begin
      if (c.s.unit.hdr_seen == 2'd0) begin
        c.s.unit.selected = (((b >> 1) & NAL_TYPE_MASK) == {2'b00, NAL_TYPE_RPU});
      end
      c.s.unit.hdr_seen = c.s.unit.hdr_seen + 2'd1;
    end else if (c.s.unit.selected) begin
      if (c.s.unit.zero_run == 2'd2 && b == ESCAPE_BYTE) begin
        c.s.unit.zero_run = 2'd0;
      end else begin
        if (b == ZERO_BYTE) begin
          c.s.unit.zero_run = (c.s.unit.zero_run < 2'd2) ? c.s.unit.zero_run + 2'd1 : 2'd2;
        end else begin
          c.s.unit.zero_run = 2'd0;
        end
        if (c.s.unit.held_valid) begin
          c = f_emit(c, c.s.unit.held, 1'b0, 1'b0);
        end
        c.s.unit.held       = b;
        c.s.unit.held_valid = 1'b1;
      end
    end
    return c;
  endfunction

  function automatic ctx_t f_end(ctx_t c, logic trunc);
    if (c.s.unit.selected && c.s.unit.held_valid) begin
      c = f_emit(c, c.s.unit.held, 1'b1, trunc);
    end
    c.s.unit = UNIT_CLEAR;
    return c;
  endfunction

  function automatic ctx_t f_length(ctx_t c, logic [7:0] b, logic [2:0] nbytes);
    if (!c.s.stopped) begin
      if (c.s.psn >= nbytes && c.s.lr != 32'd0) begin
        c = f_feed(c, b);
        c.s.lr = c.s.lr - 32'd1;
        if (c.s.lr == 32'd0) begin
          c = f_end(c, 1'b0);
          c.s.psn = 3'd0;
        end
      end else begin
        c.s.lr = {c.s.lr[23:0], b};
        if (c.s.psn != 3'd7) begin
          c.s.psn = c.s.psn + 3'd1;
        end
        if (c.s.psn >= nbytes) begin
          if (c.s.lr == 32'd0) begin
            c.s.stopped = 1'b1;
          end else begin
            c.s.unit = UNIT_CLEAR;
          end
        end
      end
    end
    return c;
  endfunction

  function automatic ctx_t f_annexb(ctx_t c, logic [7:0] b);
    if (c.s.fm == FM_SEARCH) begin
      if (b == ZERO_BYTE) begin
        c.s.lc = (c.s.lc < 2'd2) ? c.s.lc + 2'd1 : 2'd2;
      end else if (b == START_BYTE && c.s.lc >= 2'd2) begin
        c.s.fm   = FM_UNIT;
        c.s.lc   = 2'd0;
        c.s.unit = UNIT_CLEAR;
      end else begin
        c.s.lc = 2'd0;
      end
    end else if (b == ZERO_BYTE) begin
      if (c.s.lc < 2'd2) begin
        c.s.lc = c.s.lc + 2'd1;
      end else begin
        c      = f_end(c, 1'b0);
        c.s.fm = FM_SEARCH;
        c.s.lc = 2'd2;
      end
    end else if (b == START_BYTE && c.s.lc >= 2'd2) begin
      c      = f_end(c, 1'b0);
      c.s.lc = 2'd0;
    end else begin
      if (c.s.lc >= 2'd1) begin
        c = f_feed(c, ZERO_BYTE);
      end
      if (c.s.lc >= 2'd2) begin
        c = f_feed(c, ZERO_BYTE);
      end
      c      = f_feed(c, b);
      c.s.lc = 2'd0;
    end
    return c;
  endfunction

  function automatic ctx_t f_finish(ctx_t c, logic [2:0] nbytes);
    if (c.s.fm == FM_UNIT) begin
      c = f_end(c, 1'b0);
    end else if (c.s.fm == FM_LENGTH && !c.s.stopped && c.s.psn >= nbytes &&
                 c.s.lr != 32'd0) begin
      c = f_end(c, 1'b1);
    end
    c.s = FS_RESET;
    return c;
  endfunction

  logic [2:0] len_bytes;
  logic [2:0] lb;
  fs_t        st;
  logic       rp_active;
  logic       rp_active_next;
  logic [1:0] rp_idx;
  logic [1:0] rp_idx_next;
  logic [1:0] rp_n;
  logic [1:0] rp_n_next;
  logic [7:0] rp_byte;
  logic [7:0] rp_byte_next;
  logic       rp_last;
  logic       rp_last_next;
  logic [7:0] rp_cur;
  logic       go;
  ctx_t       ctx;

  assign lb = (len_bytes < LEN_BYTES_MIN) ? LEN_BYTES_MIN :
              (len_bytes > LEN_BYTES_MAX) ? LEN_BYTES_MAX : len_bytes;

  assign pkt_ready = !rp_active && !q_full;
  assign go        = !q_full && (rp_active || pkt_valid);

  always_comb begin
    unique case (rp_idx)
      2'd0:    rp_cur = st.la0;
      2'd1:    rp_cur = st.la1;
      2'd2:    rp_cur = (rp_n == 2'd3) ? ZERO_BYTE : rp_byte;
      default: rp_cur = rp_byte;
    endcase
  end

  always_comb begin
    ctx            = '0;
    ctx.s          = st;
    rp_active_next = rp_active;
    rp_idx_next    = rp_idx;
    rp_n_next      = rp_n;
    rp_byte_next   = rp_byte;
    rp_last_next   = rp_last;
    if (go) begin
      if (rp_active) begin
        ctx = f_length(ctx, rp_cur, lb);
        if (rp_idx == rp_n) begin
          rp_active_next = 1'b0;
          if (rp_last) begin
            ctx = f_finish(ctx, lb);
          end
        end else begin
          rp_idx_next = rp_idx + 2'd1;
        end
      end else begin
        unique case (st.fm)
          FM_UNDECIDED: begin
            if (st.lc < 2'd2) begin
              if (st.lc == 2'd0) begin
                ctx.s.la0 = pkt_item.in_byte;
              end else begin
                ctx.s.la1 = pkt_item.in_byte;
              end
              ctx.s.lc = st.lc + 2'd1;
            end else if (st.lc == 2'd2 && st.la0 == ZERO_BYTE && st.la1 == ZERO_BYTE &&
                         pkt_item.in_byte == ZERO_BYTE && !pkt_item.in_last) begin
              ctx.s.lc = 2'd3;
            end else if ((st.lc == 2'd2 && st.la0 == ZERO_BYTE && st.la1 == ZERO_BYTE &&
                          pkt_item.in_byte == START_BYTE) ||
                         (st.lc == 2'd3 && pkt_item.in_byte == START_BYTE)) begin
              ctx.s.fm   = FM_UNIT;
              ctx.s.lc   = 2'd0;
              ctx.s.unit = UNIT_CLEAR;
            end else begin
              ctx.s.fm       = FM_LENGTH;
              ctx.s.lc       = 2'd0;
              ctx.s.lr       = 32'd0;
              ctx.s.psn      = 3'd0;
              rp_active_next = 1'b1;
              rp_idx_next    = 2'd0;
              rp_n_next      = st.lc;
              rp_byte_next   = pkt_item.in_byte;
              rp_last_next   = pkt_item.in_last;
            end
          end
          FM_LENGTH: ctx = f_length(ctx, pkt_item.in_byte, lb);
          FM_SEARCH,
          FM_UNIT:   ctx = f_annexb(ctx, pkt_item.in_byte);
        endcase
        if (pkt_item.in_last && !rp_active_next) begin
          ctx = f_finish(ctx, lb);
        end
      end
    end
  end

  assign q_push = go && (ctx.o.count != '0);
  assign q_data = ctx.o;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_bytes <= LEN_BYTES_RESET;
    end else if (cfg_wr_en) begin
      len_bytes <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= FS_RESET;
      rp_active <= 1'b0;
      rp_idx    <= 2'd0;
      rp_n      <= 2'd0;
      rp_last   <= 1'b0;
    end else if (go) begin
      st        <= ctx.s;
      rp_active <= rp_active_next;
      rp_idx    <= rp_idx_next;
      rp_n      <= rp_n_next;
      rp_last   <= rp_last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rp_byte <= rp_byte_next;
    end
  end

endmodule : hrnd_front
`default_nettype wire

// ===== rtl/hrnd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrnd_queue
// Short FIFO of result bundles between the parser and the output serializer.
// ----------------------------------------------------------------------------
module hrnd_queue
  import hrnd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire bundle_t push_data,
  output logic         full,
  input  wire logic    pop,
  output bundle_t      pop_data,
  output logic         empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned QC_W  = $clog2(DEPTH + 1);

  bundle_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [QC_W-1:0]  fill;
  logic             do_push;
  logic             do_pop;
  bundle_t          rd_data;

  assign full     = (fill == QC_W'(DEPTH));
  assign empty    = (fill == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = rd_data;

  assign rd_ptr_next = !do_pop ? rd_ptr :
                       (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      rd_ptr <= rd_ptr_next;
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // read the next head entry, passing through an item written to it this cycle
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
    if (do_push && wr_ptr == rd_ptr_next) begin
      rd_data <= push_data;
    end else begin
      rd_data <= mem[rd_ptr_next];
    end
  end

endmodule : hrnd_queue
`default_nettype wire

// ===== rtl/hrnd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrnd_back
// Output serializer: delivers the results of each bundle one per handshake.
// ----------------------------------------------------------------------------
module hrnd_back
  import hrnd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    q_empty,
  input  wire bundle_t q_data,
  output logic         q_pop,
  output logic         nal_valid,
  input  wire logic    nal_ready,
  output nal_item_t    nal_item
);

  bundle_t          cur;
  logic             cur_valid;
  logic [IDX_W-1:0] idx;
  logic             take;
  logic             done;
  logic             load;

  assign nal_valid = cur_valid;
  assign nal_item  = cur.res[idx];
  assign take      = cur_valid && nal_ready;
  assign done      = take && ((CNT_W'(idx) + 1'b1) == cur.count);
  assign load      = !q_empty && (!cur_valid || done);
  assign q_pop     = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (done) begin
      cur_valid <= 1'b0;
    end else if (take) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_data;
    end
  end

endmodule : hrnd_back
`default_nettype wire

// ===== rtl/hevc_rpu_nal_deframer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hevc_rpu_nal_deframer_core
// Extracts unescaped type-62 NAL unit payloads from a byte stream.
// ----------------------------------------------------------------------------
// Takes one packet byte per cycle unless the queue is full. The only other
// exception is a packet that turns out to use length prefixes: once that is
// decided, the three or four opening bytes held for detection are run through
// the length parser one per cycle, so the byte input stalls once per packet
// while they are replayed. Each byte yields a bundle of up to four results
// into a QUEUE_DEPTH-entry queue; the output delivers one result per cycle
// while nal_ready is high, so multi-result bytes stall input once it fills.
module hevc_rpu_nal_deframer_core
  import hrnd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       pkt_valid,
  output logic            pkt_ready,
  input  wire pkt_item_t  pkt_item,
  output logic            nal_valid,
  input  wire logic       nal_ready,
  output nal_item_t       nal_item,
  input  wire logic       cfg_wr_en,
  input  wire logic [2:0] cfg_wr_data
);

  logic    q_full;
  logic    q_push;
  bundle_t q_wdata;
  logic    q_empty;
  logic    q_pop;
  bundle_t q_rdata;

  hrnd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pkt_valid   (pkt_valid),
    .pkt_ready   (pkt_ready),
    .pkt_item    (pkt_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  hrnd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  hrnd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .nal_valid (nal_valid),
    .nal_ready (nal_ready),
    .nal_item  (nal_item)
  );

endmodule : hevc_rpu_nal_deframer_core
`default_nettype wire

// ===== test/tb_hevc_rpu_nal_deframer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hevc_rpu_nal_deframer_core
// Self-checking testbench of the RPU NAL deframer core.
// ----------------------------------------------------------------------------
// Drives packets one byte per item. A short directed table comes first. Random
// Annex-B, length-prefix and noise packets follow, under several prefix widths
// and idle patterns, one of them with a long output hold-off. A behavioral
// deframer works out the NAL items of each accepted byte. The output stream is
// compared in order, field by field, with them or with typed rows' own items.
// ----------------------------------------------------------------------------
module tb_hevc_rpu_nal_deframer_core;
  import hrnd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned HOLD_CYCLES   = 250;
  localparam int unsigned PHASE_ITEMS   = 60;
  localparam int unsigned NUM_PHASES    = 6;

  typedef enum logic [1:0] {
    FRM_UNDECIDED,
    FRM_SEARCH,
    FRM_IN_UNIT,
    FRM_LENGTH
  } frame_mode_e;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_TYPED,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e       kind;
    logic [7:0]      data;
    logic            last;
    logic [1:0]      n_exp;
    nal_item_t [1:0] exp;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       pkt_valid = 1'b0;
  logic       pkt_ready;
  pkt_item_t  pkt_item = '0;
  logic       nal_valid;
  logic       nal_ready = 1'b0;
  nal_item_t  nal_item;
  logic       cfg_wr_en = 1'b0;
  logic [2:0] cfg_wr_data = LEN_BYTES_RESET;

  int unsigned cycle_n = 0;
  int unsigned errors = 0;
  int unsigned tx_idle_pct = 30;
  int unsigned rx_idle_pct = 61;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;

  logic [2:0]  len_cfg = LEN_BYTES_RESET;
  frame_mode_e frm_mode;
  logic [7:0]  look_bytes [3];
  int unsigned look_n;
  int unsigned prefix_n;
  int unsigned hdr_n;
  int unsigned zero_n;
  logic [31:0] len_left;
  logic        unit_sel;
  logic        held_v;
  logic        stopped;
  logic [7:0]  held_byte;
  nal_item_t   step_items [$];
  nal_item_t   nal_expect_q [$];
  nal_item_t   want;
  logic [7:0]  pkt_bytes [$];

  hevc_rpu_nal_deframer_core dut (
    .clk         (clk),
    .rst         (rst),
    .pkt_valid   (pkt_valid),
    .pkt_ready   (pkt_ready),
    .pkt_item    (pkt_item),
    .nal_valid   (nal_valid),
    .nal_ready   (nal_ready),
    .nal_item    (nal_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      nal_ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      nal_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      nal_ready <= 1'b0;
    end else begin
      nal_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && nal_valid && nal_ready) begin
      if (nal_expect_q.size() == 0) begin
        $error("unexpected NAL item: byte %02h last %0b truncated %0b",
               nal_item.out_byte, nal_item.out_last, nal_item.out_truncated);
        errors++;
      end else begin
        want = nal_expect_q.pop_front();
        if (nal_item.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, nal_item.out_byte);
          errors++;
        end
        if (nal_item.out_last !== want.out_last) begin
          $error("out_last: expected %0b, got %0b", want.out_last, nal_item.out_last);
          errors++;
        end
        if (nal_item.out_truncated !== want.out_truncated) begin
          $error("out_truncated: expected %0b, got %0b",
                 want.out_truncated, nal_item.out_truncated);
          errors++;
        end
      end
    end
  end

  function automatic void add_expect(nal_item_t it);
    nal_expect_q.insert(nal_expect_q.size(), it);
  endfunction

  function automatic void add_byte(logic [7:0] b);
    pkt_bytes.insert(pkt_bytes.size(), b);
  endfunction

  function automatic int unsigned prefix_width();
    if (len_cfg < LEN_BYTES_MIN) return LEN_BYTES_MIN;
    if (len_cfg > LEN_BYTES_MAX) return LEN_BYTES_MAX;
    return len_cfg;
  endfunction

  function automatic void push_item(logic [7:0] b, logic l, logic t);
    nal_item_t it;
    it = {b, l, t};
    if (step_items.size() < MAX_RESULTS) step_items.insert(step_items.size(), it);
  endfunction

  function automatic void clear_unit();
    hdr_n     = 0;
    unit_sel  = 1'b0;
    zero_n    = 0;
    held_v    = 1'b0;
    held_byte = '0;
  endfunction

  function automatic void clear_packet();
    frm_mode   = FRM_UNDECIDED;
    look_bytes = '{default: '0};
    look_n     = 0;
    len_left   = '0;
    prefix_n   = 0;
    stopped    = 1'b0;
    clear_unit();
  endfunction

  function automatic void unit_feed(logic [7:0] b);
    if (hdr_n < 2) begin
      if (hdr_n == 0) unit_sel = (b[6:1] == NAL_TYPE_RPU);
      hdr_n++;
    end else if (unit_sel) begin
      if (zero_n >= 2 && b == ESCAPE_BYTE) begin
        zero_n = 0;
      end else begin
        zero_n = (b != ZERO_BYTE) ? 0 : (zero_n < 2) ? zero_n + 1 : 2;
        if (held_v) push_item(held_byte, 1'b0, 1'b0);
        held_byte = b;
        held_v    = 1'b1;
      end
    end
  endfunction

  function automatic void unit_end(logic trunc);
    if (unit_sel && held_v) push_item(held_byte, 1'b1, trunc);
    clear_unit();
  endfunction

  function automatic void length_byte(logic [7:0] b);
    int unsigned lb;
    lb = prefix_width();
    if (!stopped) begin
      if (prefix_n >= lb && len_left != 0) begin
        unit_feed(b);
        len_left--;
        if (len_left == 0) begin
          unit_end(1'b0);
          prefix_n = 0;
        end
      end else begin
        len_left = {len_left[23:0], b};
        if (prefix_n < 7) prefix_n++;
        if (prefix_n >= lb) begin
          if (len_left == 0) stopped = 1'b1;
          else clear_unit();
        end
      end
    end
  endfunction

  function automatic void annexb_byte(logic [7:0] b);
    int unsigned i;
    if (frm_mode == FRM_SEARCH) begin
      if (b == ZERO_BYTE) begin
        look_n = (look_n < 2) ? look_n + 1 : 2;
      end else if (b == START_BYTE && look_n >= 2) begin
        frm_mode = FRM_IN_UNIT;
        look_n   = 0;
        clear_unit();
      end else begin
        look_n = 0;
      end
    end else if (b == ZERO_BYTE) begin
      if (look_n < 2) begin
        look_n++;
      end else begin
        unit_end(1'b0);
        frm_mode = FRM_SEARCH;
        look_n   = 2;
      end
    end else if (b == START_BYTE && look_n >= 2) begin
      unit_end(1'b0);
      look_n = 0;
    end else begin
      for (i = 0; i < look_n && i < 2; i++) unit_feed(ZERO_BYTE);
      unit_feed(b);
      look_n = 0;
    end
  endfunction

  function automatic void start_length(int unsigned n, logic [7:0] b);
    int unsigned i;
    frm_mode = FRM_LENGTH;
    look_n   = 0;
    len_left = '0;
    prefix_n = 0;
    for (i = 0; i < n && i < 3; i++) length_byte(look_bytes[i]);
    length_byte(b);
  endfunction

  function automatic void start_annexb();
    frm_mode = FRM_IN_UNIT;
    look_n   = 0;
    clear_unit();
  endfunction

  function automatic void decide_byte(logic [7:0] b, logic last);
    logic lead_zeros;
    lead_zeros = (look_bytes[0] == ZERO_BYTE && look_bytes[1] == ZERO_BYTE);
    if (look_n < 2) begin
      look_bytes[look_n] = b;
      look_n++;
    end else if (look_n == 2) begin
      if (lead_zeros && b == START_BYTE) begin
        start_annexb();
      end else if (lead_zeros && b == ZERO_BYTE && !last) begin
        look_bytes[2] = ZERO_BYTE;
        look_n        = 3;
      end else begin
        start_length(2, b);
      end
    end else if (b == START_BYTE) begin
      start_annexb();
    end else begin
      start_length(3, b);
    end
  endfunction

  function automatic void deframe_byte(logic [7:0] b, logic last);
    step_items.delete();
    if (frm_mode == FRM_UNDECIDED) decide_byte(b, last);
    else if (frm_mode == FRM_LENGTH) length_byte(b);
    else annexb_byte(b);
    if (last) begin
      if (frm_mode == FRM_IN_UNIT) begin
        unit_end(1'b0);
      end else if (frm_mode == FRM_LENGTH && !stopped && prefix_n >= prefix_width() &&
                   len_left != 0) begin
        unit_end(1'b1);
      end
      clear_packet();
    end
  endfunction

  function automatic stim_row_t stim_row(row_kind_e k, logic [7:0] d, logic l = 1'b0,
                                         logic [1:0] n = 2'd0, nal_item_t e0 = '0,
                                         nal_item_t e1 = '0);
    stim_row_t r;
    r.kind   = k;
    r.data   = d;
    r.last   = l;
    r.n_exp  = n;
    r.exp[0] = e0;
    r.exp[1] = e1;
    return r;
  endfunction

  function automatic logic [7:0] rand_body_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return ZERO_BYTE;
    if (r < 40) return ESCAPE_BYTE;
    if (r < 48) return START_BYTE;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] rand_hdr_byte();
    if ($urandom_range(99) < 70)
      return {1'($urandom_range(1)), NAL_TYPE_RPU, 1'($urandom_range(1))};
    return 8'($urandom_range(255));
  endfunction

  function automatic void make_packet();
    int unsigned kind, units, n, lb, i, u, len;
    logic        big;
    pkt_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 45) begin
      units = $urandom_range(1, 3);
      for (u = 0; u < units; u++) begin
        if ($urandom_range(1) != 0) add_byte(ZERO_BYTE);
        add_byte(ZERO_BYTE);
        add_byte(ZERO_BYTE);
        add_byte(START_BYTE);
        n = ($urandom_range(99) < 15) ? $urandom_range(0, 2) : $urandom_range(3, 9);
        for (i = 0; i < n; i++) add_byte(i == 0 ? rand_hdr_byte() : rand_body_byte());
      end
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, 3)) add_byte(ZERO_BYTE);
    end else if (kind < 85) begin
      lb    = prefix_width();
      units = $urandom_range(1, 3);
      for (u = 0; u < units; u++) begin
        n   = $urandom_range(99);
        big = (n >= 94 && lb > 1);
        len = (n < 8) ? 0 : (n < 18) ? $urandom_range(1, 2) : $urandom_range(3, 10);
        if (big) begin
          add_byte(8'($urandom_range(1, 255)));
          for (i = 1; i < lb; i++) add_byte(8'($urandom_range(255)));
          len = $urandom_range(3, 10);
        end else begin
          for (i = lb; i > 0; i--) add_byte(8'(len >> (8 * (i - 1))));
        end
        for (i = 0; i < len; i++) add_byte(i == 0 ? rand_hdr_byte() : rand_body_byte());
        if (len == 0) repeat ($urandom_range(0, 3)) add_byte(rand_body_byte());
        if (len == 0 || big) break;
      end
      if ($urandom_range(99) < 15) begin
        n = $urandom_range(1, 3);
        while (n != 0 && pkt_bytes.size() > 1) begin
          void'(pkt_bytes.pop_back());
          n--;
        end
      end
    end else begin
      repeat ($urandom_range(1, 8)) add_byte(rand_body_byte());
    end
  endfunction

  task automatic send_row(stim_row_t r);
    int unsigned i;
    pkt_item  <= {r.data, r.last};
    pkt_valid <= 1'b1;
    @(posedge clk);
    while (!pkt_ready) @(posedge clk);
    deframe_byte(r.data, r.last);
    if (r.kind == ROW_TYPED) begin
      for (i = 0; i < r.n_exp; i++) add_expect(r.exp[i]);
    end else begin
      for (i = 0; i < step_items.size(); i++) add_expect(step_items[i]);
    end
    if ($urandom_range(99) < tx_idle_pct) begin
      pkt_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic send_packet();
    stim_row_t r;
    r = '0;
    foreach (pkt_bytes[i]) begin
      r.data = pkt_bytes[i];
      r.last = (i == pkt_bytes.size() - 1);
      send_row(r);
    end
  endtask

  task automatic drain(int unsigned settle);
    while (nal_expect_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_len_cfg(logic [2:0] v);
    pkt_valid <= 1'b0;
    drain(SETTLE_CYCLES);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    len_cfg = v;
  endtask

  initial begin
    stim_row_t   dir_tab [$];
    logic [2:0]  phase_cfg [NUM_PHASES];
    int unsigned phase_n, p;
    dir_tab = '{
      // Annex-B, three-byte start code, escape after two zeros, unescaped payload 00 00 ff
      stim_row(ROW_TYPED, 8'h00),
      stim_row(ROW_TYPED, 8'h00),
      stim_row(ROW_TYPED, 8'h01),
      stim_row(ROW_TYPED, 8'h7c),
      stim_row(ROW_TYPED, 8'h01),
      stim_row(ROW_TYPED, 8'h00),
      stim_row(ROW_TYPED, 8'h00),
      stim_row(ROW_TYPED, 8'h03, 1'b0, 2'd1, {8'h00, 1'b0, 1'b0}),
      stim_row(ROW_TYPED, 8'hff, 1'b1, 2'd2, {8'h00, 1'b0, 1'b0}, {8'hff, 1'b1, 1'b0}),
      // packet too short to decide framing
      stim_row(ROW_TYPED, 8'h00, 1'b1),
      // three zeros then packet end
      stim_row(ROW_TYPED, 8'h00),
      stim_row(ROW_TYPED, 8'h00),
      stim_row(ROW_TYPED, 8'h00, 1'b1),
      // one-byte prefixes, unit then zero length stops the packet
      stim_row(ROW_CFG, {5'd0, LEN_BYTES_MIN}),
      stim_row(ROW_PREDICT, 8'h03),
      stim_row(ROW_PREDICT, 8'h7c),
      stim_row(ROW_PREDICT, 8'h01),
      stim_row(ROW_PREDICT, 8'haa),
      stim_row(ROW_PREDICT, 8'h00),
      stim_row(ROW_PREDICT, 8'h55, 1'b1),
      // width 7 then 0 mid-packet, unit cut short by packet end
      stim_row(ROW_CFG, 8'd7),
      stim_row(ROW_PREDICT, 8'h05),
      stim_row(ROW_CFG, 8'd0),
      stim_row(ROW_PREDICT, 8'h7d),
      stim_row(ROW_PREDICT, 8'h01),
      stim_row(ROW_PREDICT, 8'h00),
      stim_row(ROW_TYPED, 8'hee, 1'b1, 2'd2, {8'h00, 1'b0, 1'b0}, {8'hee, 1'b1, 1'b1})
    };
    phase_cfg = '{3'd2, LEN_BYTES_MAX, 3'd0, 3'd7, 3'd3, LEN_BYTES_MIN};
    clear_packet();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) write_len_cfg(dir_tab[i].data[2:0]);
      else send_row(dir_tab[i]);
    end
    for (p = 0; p < NUM_PHASES; p++) begin
      write_len_cfg(phase_cfg[p]);
      if (p == 2) begin
        tx_idle_pct = 61;
        rx_idle_pct <= 30;
      end
      if (p == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_req    <= hold_req + 1;
      end
      phase_n = 0;
      while (phase_n < PHASE_ITEMS) begin
        make_packet();
        phase_n += pkt_bytes.size();
        send_packet();
      end
    end
    pkt_valid <= 1'b0;
    drain(SETTLE_CYCLES);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule : tb_hevc_rpu_nal_deframer_core

// ===== files.f =====
rtl/hrnd_pkg.sv
rtl/hrnd_front.sv
rtl/hrnd_queue.sv
rtl/hrnd_back.sv
rtl/hevc_rpu_nal_deframer_core.sv
test/tb_hevc_rpu_nal_deframer_core.sv
